@@ src/lpd_pkg.sv @@
// Shared types and constants for the length-prefixed deframer.
package lpd_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int CMD_BYTES    = 4;
  localparam int ID_END       = 8;

  localparam logic [3:0]  HDR_LAST_COUNT  = 4'(HEADER_BYTES - 1);
  localparam logic [3:0]  CMD_END_COUNT   = 4'(CMD_BYTES);
  localparam logic [3:0]  ID_END_COUNT    = 4'(ID_END);
  localparam logic [23:0] MAX_LEN_RESET   = 24'h01_0000;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_BODY    = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  // One buffered input beat handed from the input stage to the core.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } byte_beat_t;

endpackage

@@ src/lpd_in_stage.sv @@
// Input register stage: holds one received byte until the core takes it.
module lpd_in_stage import lpd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       take,
  output byte_beat_t beat
);

  logic       valid;
  logic [7:0] data;

  assign s_tready = !valid || take;
  assign beat     = '{valid: valid, data: data};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      data <= s_tdata;
    end
  end

endmodule

@@ src/lpd_core.sv @@
// Deframer core: header assembly, body counting and the result register.
module lpd_core import lpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,
  input  byte_beat_t   beat,
  output logic         take,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,
  output logic [1:0]   m_tuser,
  output logic         m_tlast
);

  logic [23:0] max_body_len;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] cmd_word, cmd_word_next;
  logic [31:0] id_word, id_word_next;
  logic [31:0] len_word, len_word_next;
  logic [31:0] body_left, body_left_next;
  logic        in_body, in_body_next;
  logic        failed, failed_next;

  logic        res_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic        res_last;

  assign take = beat.valid && (!m_tvalid || m_tready);

  always_comb begin
    header_count_next = header_count;
    cmd_word_next     = cmd_word;
    id_word_next      = id_word;
    len_word_next     = len_word;
    body_left_next    = body_left;
    in_body_next      = in_body;
    failed_next       = failed;
    res_valid         = 1'b0;
    res_kind          = KIND_HEADER;
    res_byte          = 8'd0;
    res_last          = 1'b0;
    if (!failed) begin
      if (in_body) begin
        if (body_left != 32'd0) begin
          body_left_next = body_left - 32'd1;
        end
        res_valid = 1'b1;
        res_kind  = KIND_BODY;
        res_byte  = beat.data;
        if (body_left_next == 32'd0) begin
          in_body_next = 1'b0;
          res_last     = 1'b1;
        end
      end else begin
        // big-endian: shift the new byte into the low end of its word
        if (header_count < CMD_END_COUNT) begin
          cmd_word_next = {cmd_word[23:0], beat.data};
        end else if (header_count < ID_END_COUNT) begin
          id_word_next = {id_word[23:0], beat.data};
        end else begin
          len_word_next = {len_word[23:0], beat.data};
        end
        if (header_count < HDR_LAST_COUNT) begin
          header_count_next = header_count + 4'd1;
        end else begin
          header_count_next = 4'd0;
          res_valid         = 1'b1;
          if (len_word_next > {8'd0, max_body_len}) begin
            // oversized body: report once, then go deaf until reset
            failed_next = 1'b1;
            res_kind    = KIND_INVALID;
            res_last    = 1'b1;
          end else if (len_word_next == 32'd0) begin
            body_left_next = 32'd0;
            res_last       = 1'b1;
          end else begin
            body_left_next = len_word_next;
            in_body_next   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_body_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= 4'd0;
      cmd_word     <= 32'd0;
      id_word      <= 32'd0;
      len_word     <= 32'd0;
      body_left    <= 32'd0;
      in_body      <= 1'b0;
      failed       <= 1'b0;
    end else if (take) begin
      header_count <= header_count_next;
      cmd_word     <= cmd_word_next;
      id_word      <= id_word_next;
      len_word     <= len_word_next;
      body_left    <= body_left_next;
      in_body      <= in_body_next;
      failed       <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      m_tdata <= {res_byte, len_word_next, id_word_next, cmd_word_next};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

endmodule

@@ src/length_prefixed_deframer.sv @@
// Top level of the length-prefixed frame deframer.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata[7:0] received byte
//  m_*      out  m_tvalid / m_tready  m_tdata, m_tuser kind, m_tlast frame end
//  cfg_*    in   cfg_wr_en            cfg_wr_data max_body_len
//
// One byte per cycle sustained while m_tready is high: each byte is held in
// the input register and turned into at most one result in the result
// register by the single header/body update between the two registers.
// Reset is synchronous; max_body_len returns to 65536 and the header
// count, words and failed flag clear. A stalled result holds the result
// register while one more byte waits in the input register.
module length_prefixed_deframer import lpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // configuration
  input  logic         cfg_wr_en,
  input  logic [23:0]  cfg_wr_data,   // [23:0] max_body_len
  // byte stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,       // [7:0] in_byte
  // results out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,       // [31:0] command, [63:32] req_tag,
                                      // [95:64] body_length, [103:96] body_byte
  output logic [1:0]   m_tuser,       // [1:0] kind
  output logic         m_tlast        // frame_last
);

  byte_beat_t beat;
  logic       take;

  // input register: decouples upstream from a stalled result
  lpd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .take     (take),
    .beat     (beat)
  );

  // frame state and result register
  lpd_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .beat        (beat),
    .take        (take),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the length-prefixed deframer: byte stream in, results scored.
module tb;
  import lpd_pkg::*;

  // Watchdog: cycles with no beat on either side before the run is declared hung.
  localparam int IDLE_LIMIT   = 2000;
  // Bytes may sit in the input and result registers without producing a result.
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 8;
  // Long receiver hold-off, long enough to back the block up into s_tready.
  localparam int HOLD_CYCLES  = 80;
  // Rough byte budget per random phase.
  localparam int PHASE_BYTES  = 90;

  localparam logic [1:0]  PH_HEADER = 2'd0;
  localparam logic [1:0]  PH_BODY   = 2'd1;
  localparam logic [23:0] LIMIT_MAX = 24'hFF_FFFF;

  // One expected result, laid out like the result port.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] command;
    logic [31:0] req_tag;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        frame_last;
  } frame_result_t;

  // Tracks the deframing state, predicts results per accepted byte and scores the output.
  class frame_tracker;
    logic [23:0]   max_len;
    logic [3:0]    hdr_count;
    logic [31:0]   cmd_word;
    logic [31:0]   id_word;
    logic [31:0]   len_word;
    logic [31:0]   body_left;
    logic [1:0]    phase;
    bit            closed;
    int            errors;
    frame_result_t pending[$];

    function new();
      max_len   = MAX_LEN_RESET;
      hdr_count = '0;
      cmd_word  = '0;
      id_word   = '0;
      len_word  = '0;
      body_left = '0;
      phase     = PH_HEADER;
      closed    = 1'b0;
      errors    = 0;
    endfunction

    function void set_max(logic [23:0] v);
      max_len = v;
    endfunction

    function void push(kind_t k, logic [7:0] b, logic last);
      frame_result_t r;
      r.kind        = k;
      r.command     = cmd_word;
      r.req_tag     = id_word;
      r.body_length = len_word;
      r.body_byte   = b;
      r.frame_last  = last;
      pending.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      // after an oversized frame the link counts as closed: everything is dropped
      if (closed) return;
      if (phase == PH_BODY) begin
        if (body_left != 0) body_left--;
        if (body_left == 0) phase = PH_HEADER;
        push(KIND_BODY, b, body_left == 0);
        return;
      end
      // header words arrive big-endian
      if (hdr_count < CMD_END_COUNT)
        cmd_word = {cmd_word[23:0], b};
      else if (hdr_count < ID_END_COUNT)
        id_word = {id_word[23:0], b};
      else
        len_word = {len_word[23:0], b};
      if (hdr_count < HDR_LAST_COUNT) begin
        hdr_count++;
        phase = PH_HEADER;
        return;
      end
      hdr_count = '0;
      phase     = PH_HEADER;
      if (len_word > {8'h00, max_len}) begin
        closed = 1'b1;
        push(KIND_INVALID, 8'h00, 1'b1);
      end else if (len_word == 0) begin
        body_left = '0;
        push(KIND_HEADER, 8'h00, 1'b1);
      end else begin
        phase     = PH_BODY;
        body_left = len_word;
        push(KIND_HEADER, 8'h00, 1'b0);
      end
    endfunction

    function void match_result(logic [1:0] kind_bits, logic [103:0] data, logic last);
      frame_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: kind %0d data %0h last %0b", kind_bits, data, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (kind_bits !== e.kind) begin
        $error("kind: expected %0d actual %0d", e.kind, kind_bits);
        errors++;
      end
      if (data[31:0] !== e.command) begin
        $error("command: expected %08h actual %08h", e.command, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.req_tag) begin
        $error("req_tag: expected %08h actual %08h", e.req_tag, data[63:32]);
        errors++;
      end
      if (data[95:64] !== e.body_length) begin
        $error("body_length: expected %08h actual %08h", e.body_length, data[95:64]);
        errors++;
      end
      if (data[103:96] !== e.body_byte) begin
        $error("body_byte: expected %02h actual %02h", e.body_byte, data[103:96]);
        errors++;
      end
      if (last !== e.frame_last) begin
        $error("frame_last: expected %0b actual %0b", e.frame_last, last);
        errors++;
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic         clk         = 1'b0;
  logic         rst         = 1'b1;
  logic         cfg_wr_en   = 1'b0;
  logic [23:0]  cfg_wr_data = '0;
  logic         s_tvalid    = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata     = '0;
  logic         m_tvalid;
  logic         m_tready    = 1'b0;
  logic [103:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         m_tlast;

  frame_tracker frames;

  // sender bookkeeping: offering mirrors s_tvalid so it never gets two writes in one step
  bit offering   = 1'b0;
  int burst_left = 8;
  int sent_bytes = 0;
  // set by the stimulus, consumed by the receiver for one long hold-off
  bit hold_req   = 1'b0;
  int idle_cycles = 0;

  length_prefixed_deframer dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one byte and hold it until the beat goes through. Bursts end in random gaps.
  task automatic send_byte(input logic [7:0] b);
    if (!offering) begin
      s_tvalid <= 1'b1;
      offering = 1'b1;
    end
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    frames.take_byte(b);
    sent_bytes++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 12);
    end
  endtask

  task automatic send_header(input logic [31:0] cmd, input logic [31:0] id,
                             input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_byte(cmd[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(id[8*i +: 8]);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
  endtask

  task automatic send_frame(input logic [31:0] cmd, input logic [31:0] id,
                            input logic [31:0] len);
    send_header(cmd, id, len);
    for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  // Mostly short bodies; zero length and (for limits up to 64) the limit itself are common.
  function automatic logic [31:0] pick_len(input logic [23:0] lim);
    logic [31:0] n;
    case ($urandom_range(0, 9))
      0:       n = 0;
      1:       n = (lim <= 64) ? {8'h00, lim} : 32'($urandom_range(40, 64));
      default: n = 32'($urandom_range(1, 16));
    endcase
    if (n > {8'h00, lim}) n = {8'h00, lim};
    return n;
  endfunction

  // Stop offering, let every expected result out, then give the pipeline time to settle.
  task automatic drain();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
    while (frames.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [23:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    frames.set_max(v);
    @(posedge clk);
  endtask

  task automatic random_phase();
    int stop_at;
    stop_at = sent_bytes + PHASE_BYTES;
    while (sent_bytes < stop_at)
      send_frame($urandom, $urandom, pick_len(frames.max_len));
  endtask

  // Receiver: ready pattern in stretches of varying duty, plus the one long hold-off.
  initial begin : receiver
    int ready_pct;
    int stretch;
    ready_pct = 100;
    stretch   = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (stretch == 0) begin
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 75;
            2: ready_pct = 50;
            default: ready_pct = 20;
          endcase
          stretch = $urandom_range(8, 80);
        end
        stretch--;
        m_tready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Output monitor and watchdog. Values read here are the ones from before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      frames.match_result(m_tuser, m_tdata, m_tlast);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    frames = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all-ones command with an empty body, then all-ones id with a
    // two-byte body of extreme values (limit at its reset value).
    send_header(32'hFFFF_FFFF, 32'h0000_0000, 32'd0);
    send_header(32'h0000_0000, 32'hFFFF_FFFF, 32'd2);
    send_byte(8'hFF);
    send_byte(8'h00);

    random_phase();

    // limit of zero: only empty bodies are legal
    set_limit(24'd0);
    random_phase();

    // small limit, bodies right up to it
    set_limit(24'd7);
    random_phase();

    set_limit(24'($urandom_range(0, LIMIT_MAX)));
    random_phase();

    // Backpressure: receiver holds off while the sender streams a long body
    // with no gaps, so the block fills and drops s_tready.
    set_limit(24'd200);
    burst_left = 300;
    hold_req   = 1'b1;
    send_frame($urandom, $urandom, 32'd200);
    random_phase();

    set_limit(24'd1);
    random_phase();

    // Widest limit, then a length one past it (just beyond 24 bits): the frame
    // is rejected and everything after it is dropped for good.
    set_limit(LIMIT_MAX);
    random_phase();
    send_header($urandom, $urandom, 32'h0100_0000);
    repeat (20) send_byte(8'($urandom));

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (frames.errors == 0 && frames.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ length_prefixed_deframer.f @@
src/lpd_pkg.sv
src/lpd_in_stage.sv
src/lpd_core.sv
src/length_prefixed_deframer.sv
tb/sv/tb.sv
